// ===== src/smb_pkg.sv =====
// Shared constants and types of the service mailbox controller.
package smb_pkg;

   localparam int MAILBOX_DEPTH_DEF = 4096;

   localparam int REQ_TYPE_W = 2;
   localparam int OFFSET_W   = 12;
   localparam int SIZE_W     = 3;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int SER_LEN_W  = 5;
   localparam int CTRL_W     = 24;
   localparam int STATUS_W   = 17;

   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ACK   = 2'd2;

   localparam logic TGT_CTRL    = 1'b0;
   localparam logic TGT_MAILBOX = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_LO  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_HI  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_LEN = 2'd2;

   localparam logic [OFFSET_W-1:0] CR_OFFSET = 12'h050;
   localparam logic [OFFSET_W-1:0] SR_OFFSET = 12'h054;

   localparam logic [CTRL_W-1:0]   CR_KEEP     = 24'hFF0009;
   localparam int                  CR_REQ_BIT  = 0;
   localparam int                  CR_NTF_BIT  = 3;
   localparam logic [7:0]          CMD_SERIAL  = 8'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL = 17'h10000;
   localparam logic [SIZE_W-1:0]   CTRL_SIZE   = 3'd4;
   localparam logic [SIZE_W-1:0]   MAX_SIZE    = 3'd4;
   localparam int                  SERIAL_BYTES = 16;

   localparam logic [CSR_DATA_W-1:0] SERIAL_LO_RST  = 64'd3978425819141910832;
   localparam logic [CSR_DATA_W-1:0] SERIAL_HI_RST  = 64'd7378413942531504440;
   localparam logic [SER_LEN_W-1:0]  SERIAL_LEN_RST = 5'd16;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

endpackage

// ===== src/smb_if.sv =====
// Request and response channel interfaces of the service mailbox controller.
interface smb_req_if import smb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic                  target;
   logic [OFFSET_W-1:0]   offset;
   logic [SIZE_W-1:0]     access_size;
   logic [DATA_W-1:0]     write_data;

   modport source (output valid, req_type, target, offset, access_size, write_data,
                   input ready);
   modport sink (input valid, req_type, target, offset, access_size, write_data,
                 output ready);
endinterface

interface smb_rsp_if import smb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_level;
   logic              access_error;

   modport source (output valid, read_data, irq_level, access_error, input ready);
   modport sink (input valid, read_data, irq_level, access_error, output ready);
endinterface

// ===== src/smb_mailbox.sv =====
// Single-port byte memory of the mailbox with registered read data.
module smb_mailbox import smb_pkg::*; #(
   parameter int MAILBOX_DEPTH = MAILBOX_DEPTH_DEF,
   localparam int AW = $clog2(MAILBOX_DEPTH)
) (
   input  logic          clock,
   input  mem_cmd_type   cmd,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] mem_ff [MAILBOX_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/service_mailbox_controller.sv =====
// Top level of the service mailbox controller.
//
// One transaction is handled at a time, through a single-port byte memory that
// moves one byte per cycle. Control, acknowledge and rejected accesses go from
// acceptance to the done state; a mailbox write passes through the write
// state, a mailbox read through the read and last-read states, and a control
// write that runs the serial-number service through the service state. The
// next request is taken while the result waits in the output register. After
// reset the mailbox is cleared one byte per cycle, during which no request is
// taken; CSR writes are taken at any time.
module service_mailbox_controller import smb_pkg::*; #(
   parameter int MAILBOX_DEPTH = MAILBOX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   smb_req_if.sink               req_chan,
   smb_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAILBOX_DEPTH);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MWR   = 7'b0000100,
      S_MRD   = 7'b0001000,
      S_MRDL  = 7'b0010000,
      S_SVC   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0]         clr_ptr_ff, clr_ptr_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [1:0]            last_ff, last_in;
   logic [OFFSET_W-1:0]   base_ff, base_in;
   logic [DATA_W-1:0]     wdata_ff, wdata_in;
   logic [DATA_W-1:0]     rd_data_ff, rd_data_in;
   logic                  err_ff, err_in;
   logic                  pend_ff, pend_in;
   logic [1:0]            pidx_ff, pidx_in;
   logic [CTRL_W-1:0]     control_ff, control_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  irq_ff, irq_in;
   logic [CSR_DATA_W-1:0] serial_lo_ff, serial_hi_ff;
   logic [SER_LEN_W-1:0]  serial_len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_irq_ff, rsp_irq_in;
   logic                  rsp_err_ff, rsp_err_in;

   mem_cmd_type   mem_cmd;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;

   logic [OFFSET_W:0]  span;
   logic               mb_bad;
   logic [127:0]       serial_all;
   logic [7:0]         serial_byte;

   smb_mailbox #(.MAILBOX_DEPTH(MAILBOX_DEPTH)) u_mailbox (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign span = (OFFSET_W+1)'(req_chan.offset) + (OFFSET_W+1)'(req_chan.access_size);
   assign mb_bad = (req_chan.access_size == '0) || (req_chan.access_size > MAX_SIZE) ||
                   (32'(span) > 32'(MAILBOX_DEPTH));
   assign serial_all  = {serial_hi_ff, serial_lo_ff};
   assign serial_byte = serial_all[{cnt_ff, 3'b000} +: 8];

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_data_ff;
   assign rsp_chan.irq_level    = rsp_irq_ff;
   assign rsp_chan.access_error = rsp_err_ff;

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      wdata_in     = wdata_ff;
      rd_data_in   = rd_data_ff;
      err_in       = err_ff;
      control_in   = control_ff;
      status_in    = status_ff;
      irq_in       = irq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_err_in   = rsp_err_ff;
      mem_cmd      = '0;
      mem_addr     = '0;
      mem_wdata    = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = clr_ptr_ff;
            clr_ptr_in    = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == AW'(MAILBOX_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               base_in    = req_chan.offset;
               wdata_in   = req_chan.write_data;
               cnt_in     = '0;
               last_in    = 2'(req_chan.access_size - 3'd1);
               rd_data_in = '0;
               err_in     = 1'b0;
               state_in   = S_DONE;
               case (req_chan.req_type)
                  REQ_ACK: begin
                     irq_in = 1'b0;
                  end
                  REQ_READ, REQ_WRITE: begin
                     if (req_chan.target == TGT_CTRL) begin
                        if (req_chan.access_size != CTRL_SIZE) begin
                           err_in = 1'b1;
                        end else if (req_chan.req_type == REQ_READ) begin
                           if (req_chan.offset == CR_OFFSET) begin
                              rd_data_in = DATA_W'(control_ff);
                           end else if (req_chan.offset == SR_OFFSET) begin
                              rd_data_in = DATA_W'(status_ff);
                           end
                        end else if (req_chan.offset == CR_OFFSET) begin
                           control_in = req_chan.write_data[CTRL_W-1:0] & CR_KEEP;
                           if (req_chan.write_data[CR_REQ_BIT]) begin
                              control_in[CR_REQ_BIT] = 1'b0;
                              if (req_chan.write_data[23:16] == CMD_SERIAL) begin
                                 status_in = '0;
                                 state_in  = S_SVC;
                              end else begin
                                 status_in = STATUS_FAIL;
                              end
                              if (req_chan.write_data[CR_NTF_BIT]) begin
                                 irq_in = 1'b1;
                              end
                           end
                        end
                     end else begin
                        if (mb_bad) begin
                           err_in = 1'b1;
                        end else if (req_chan.req_type == REQ_READ) begin
                           state_in = S_MRD;
                        end else begin
                           state_in = S_MWR;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MWR: begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = AW'((OFFSET_W+1)'(base_ff) + (OFFSET_W+1)'(cnt_ff));
            mem_wdata     = wdata_ff[{cnt_ff[1:0], 3'b000} +: 8];
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff[1:0] == last_ff) begin
               state_in = S_DONE;
            end
         end
         S_MRD: begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = AW'((OFFSET_W+1)'(base_ff) + (OFFSET_W+1)'(cnt_ff));
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff[1:0] == last_ff) begin
               state_in = S_MRDL;
            end
         end
         S_MRDL: begin
            state_in = S_DONE;
         end
         S_SVC: begin
            mem_cmd.wr_en = 1'b1;
            mem_addr      = AW'(cnt_ff);
            mem_wdata     = ({1'b0, cnt_ff} < serial_len_ff) ? serial_byte : 8'd0;
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == 4'(SERIAL_BYTES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data_ff;
               rsp_irq_in   = irq_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // collect the byte that returns in the cycle after its read
      pend_in = mem_cmd.rd_en;
      pidx_in = cnt_ff[1:0];
      if (pend_ff) begin
         rd_data_in[{pidx_ff, 3'b000} +: 8] = mem_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ptr_ff    <= '0;
         pend_ff       <= 1'b0;
         control_ff    <= '0;
         status_ff     <= '0;
         irq_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         serial_lo_ff  <= SERIAL_LO_RST;
         serial_hi_ff  <= SERIAL_HI_RST;
         serial_len_ff <= SERIAL_LEN_RST;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         pend_ff      <= pend_in;
         control_ff   <= control_in;
         status_ff    <= status_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SERIAL_LO:  serial_lo_ff  <= csr_wdata;
               CSR_SERIAL_HI:  serial_hi_ff  <= csr_wdata;
               CSR_SERIAL_LEN: serial_len_ff <= csr_wdata[SER_LEN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      base_ff     <= base_in;
      wdata_ff    <= wdata_in;
      rd_data_ff  <= rd_data_in;
      err_ff      <= err_in;
      pidx_ff     <= pidx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule

// ===== dv/tb_service_mailbox_controller.sv =====
// Self-checking testbench of the service mailbox controller: control window, service runs, mailbox.
module tb_service_mailbox_controller;
   import smb_pkg::*;

   localparam int MBOX_DEPTH = MAILBOX_DEPTH_DEF;
   localparam logic [REQ_TYPE_W-1:0] REQ_NONE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0]  CSR_UNUSED = 2'd3;
   localparam logic [OFFSET_W-1:0]   OFS_FIRST  = 12'h000;
   localparam logic [OFFSET_W-1:0]   OFS_LAST   = 12'hFFF;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  target;
      logic [OFFSET_W-1:0]   offset;
      logic [SIZE_W-1:0]     access_size;
      logic [DATA_W-1:0]     write_data;
   } mbox_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_level;
      logic              access_error;
   } mbox_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   smb_req_if req_if ();
   smb_rsp_if rsp_if ();

   service_mailbox_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [127:0]         serial_model;
   logic [SER_LEN_W-1:0] ser_len_model;
   logic [CTRL_W-1:0]    ctrl_model;
   logic [STATUS_W-1:0]  status_model;
   logic [7:0]           mbox_model [0:MBOX_DEPTH-1];
   logic                 irq_model;

   mbox_req_type pending_req [$];
   mbox_rsp_type expected_rsp [$];
   mbox_req_type drive_item;

   int errors = 0;
   int checked = 0;
   int service_runs = 0;
   int csr_settings = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_stall = 0;
   int rsp_calm = 0;

   always #1 clock = ~clock;

   task automatic flag_error(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic int idle_cycles(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic mbox_rsp_type serve_request(mbox_req_type it);
      mbox_rsp_type r;
      int unsigned len;
      r = '0;
      if (it.req_type == REQ_ACK) begin
         irq_model = 1'b0;
      end else if (it.req_type == REQ_READ || it.req_type == REQ_WRITE) begin
         if (it.target == TGT_CTRL) begin
            if (it.access_size != CTRL_SIZE) begin
               r.access_error = 1'b1;
            end else if (it.req_type == REQ_READ) begin
               if (it.offset == CR_OFFSET) r.read_data = {8'h00, ctrl_model};
               else if (it.offset == SR_OFFSET) r.read_data = {15'h0000, status_model};
            end else if (it.offset == CR_OFFSET) begin
               ctrl_model = it.write_data[CTRL_W-1:0] & CR_KEEP;
               if (it.write_data[CR_REQ_BIT]) begin
                  service_runs++;
                  ctrl_model[CR_REQ_BIT] = 1'b0;
                  len = (ser_len_model > SERIAL_BYTES) ? SERIAL_BYTES : ser_len_model;
                  if (it.write_data[23:16] == CMD_SERIAL) begin
                     for (int i = 0; i < SERIAL_BYTES; i++)
                        mbox_model[i] = (i < len) ? serial_model[8*i +: 8] : 8'h00;
                     status_model = '0;
                  end else begin
                     status_model = STATUS_FAIL;
                  end
                  if (it.write_data[CR_NTF_BIT]) irq_model = 1'b1;
               end
            end
         end else begin
            if (it.access_size == 0 || it.access_size > MAX_SIZE ||
                int'(it.offset) + int'(it.access_size) > MBOX_DEPTH) begin
               r.access_error = 1'b1;
            end else if (it.req_type == REQ_READ) begin
               for (int i = 0; i < it.access_size; i++)
                  r.read_data[8*i +: 8] = mbox_model[it.offset + i];
            end else begin
               for (int i = 0; i < it.access_size; i++)
                  mbox_model[it.offset + i] = it.write_data[8*i +: 8];
            end
         end
      end
      r.irq_level = irq_model;
      return r;
   endfunction

   function automatic mbox_req_type make_req(logic [REQ_TYPE_W-1:0] kind, logic tgt,
                                             logic [OFFSET_W-1:0] ofs, int unsigned size,
                                             logic [DATA_W-1:0] data);
      mbox_req_type it;
      it.req_type    = kind;
      it.target      = tgt;
      it.offset      = ofs;
      it.access_size = SIZE_W'(size);
      it.write_data  = data;
      return it;
   endfunction

   function automatic mbox_req_type random_req();
      mbox_req_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      it.req_type    = ($urandom_range(0, 1) == 0) ? REQ_READ : REQ_WRITE;
      it.target      = TGT_MAILBOX;
      it.access_size = SIZE_W'($urandom_range(1, 4));
      it.write_data  = $urandom;
      it.offset      = OFFSET_W'($urandom_range(0, 31));
      if (pick < 15) begin
         it.offset = OFFSET_W'(MBOX_DEPTH - $urandom_range(1, 8));
      end else if (pick < 25) begin
         it.offset = OFFSET_W'($urandom);
      end else if (pick < 40) begin
         it.target      = TGT_CTRL;
         it.access_size = CTRL_SIZE;
         it.offset      = ($urandom_range(0, 2) == 0) ? SR_OFFSET : CR_OFFSET;
         if ($urandom_range(0, 1) == 0) it.write_data[23:16] = CMD_SERIAL;
         if ($urandom_range(0, 3) != 0) it.write_data[CR_REQ_BIT] = 1'b1;
      end else if (pick < 48) begin
         it.req_type    = REQ_ACK;
         it.target      = 1'($urandom);
         it.offset      = OFFSET_W'($urandom);
         it.access_size = SIZE_W'($urandom);
      end else if (pick < 60) begin
         it.req_type    = REQ_TYPE_W'($urandom);
         it.target      = 1'($urandom);
         it.offset      = ($urandom_range(0, 1) == 0) ? OFFSET_W'($urandom)
                                                      : OFFSET_W'($urandom_range(80, 87));
         it.access_size = SIZE_W'($urandom);
      end
      return it;
   endfunction

   task automatic set_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SERIAL_LO:  serial_model[63:0]   = value;
         CSR_SERIAL_HI:  serial_model[127:64] = value;
         CSR_SERIAL_LEN: ser_len_model        = value[SER_LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_if.valid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int count);
      csr_settings++;
      @(negedge clock);
      repeat (count) pending_req.push_back(random_req());
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsp.push_back(serve_request(drive_item));
            req_gap = idle_cycles(req_calm);
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               drive_item = pending_req.pop_front();
               req_if.valid       <= 1'b1;
               req_if.req_type    <= drive_item.req_type;
               req_if.target      <= drive_item.target;
               req_if.offset      <= drive_item.offset;
               req_if.access_size <= drive_item.access_size;
               req_if.write_data  <= drive_item.write_data;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      mbox_rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            checked++;
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("response with no request outstanding, read_data %08h",
                                    rsp_if.read_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_if.read_data !== want.read_data)
                  flag_error($sformatf("read_data %08h, expected %08h",
                                       rsp_if.read_data, want.read_data));
               if (rsp_if.irq_level !== want.irq_level)
                  flag_error($sformatf("irq_level %b, expected %b",
                                       rsp_if.irq_level, want.irq_level));
               if (rsp_if.access_error !== want.access_error)
                  flag_error($sformatf("access_error %b, expected %b",
                                       rsp_if.access_error, want.access_error));
            end
            rsp_stall = idle_cycles(rsp_calm);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_READ;
      req_if.target      = TGT_CTRL;
      req_if.offset      = '0;
      req_if.access_size = '0;
      req_if.write_data  = '0;
      rsp_if.ready       = 1'b0;
      serial_model       = {SERIAL_HI_RST, SERIAL_LO_RST};
      ser_len_model      = SERIAL_LEN_RST;
      ctrl_model         = '0;
      status_model       = '0;
      irq_model          = 1'b0;
      for (int i = 0; i < MBOX_DEPTH; i++) mbox_model[i] = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      csr_settings++;
      @(negedge clock);
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    CR_OFFSET, 4, 32'h0));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    SR_OFFSET, 4, 32'h0));
      pending_req.push_back(make_req(REQ_READ,  TGT_MAILBOX, OFS_FIRST, 4, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    CR_OFFSET, 4, 32'h0000_0009));
      for (int i = 0; i < 4; i++)
         pending_req.push_back(make_req(REQ_READ, TGT_MAILBOX, OFFSET_W'(4 * i), 4, 32'h0));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    CR_OFFSET, 4, 32'h0));
      pending_req.push_back(make_req(REQ_ACK,   TGT_CTRL,    OFS_FIRST, 0, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    CR_OFFSET, 4, 32'hFF5A_FFF1));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    SR_OFFSET, 4, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    CR_OFFSET, 4, 32'hFFFF_FFFE));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    SR_OFFSET, 4, 32'hFFFF_FFFF));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    CR_OFFSET, 4, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    OFS_LAST,  4, 32'hFFFF_FFFF));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    OFS_FIRST, 4, 32'h0));
      pending_req.push_back(make_req(REQ_READ,  TGT_CTRL,    CR_OFFSET, 2, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    CR_OFFSET, 0, 32'h0000_0009));
      pending_req.push_back(make_req(REQ_WRITE, TGT_MAILBOX, 12'hFFC,   4, 32'hDEAD_BEEF));
      pending_req.push_back(make_req(REQ_READ,  TGT_MAILBOX, 12'hFFC,   4, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_MAILBOX, 12'hFFD,   4, 32'h1234_5678));
      pending_req.push_back(make_req(REQ_READ,  TGT_MAILBOX, OFS_LAST,  1, 32'h0));
      pending_req.push_back(make_req(REQ_READ,  TGT_MAILBOX, 12'h010,   0, 32'h0));
      pending_req.push_back(make_req(REQ_WRITE, TGT_MAILBOX, 12'h010,   7, 32'hFFFF_FFFF));
      pending_req.push_back(make_req(REQ_WRITE, TGT_MAILBOX, 12'h064,   3, 32'hA5C3_0F81));
      pending_req.push_back(make_req(REQ_READ,  TGT_MAILBOX, 12'h064,   3, 32'h0));
      pending_req.push_back(make_req(REQ_NONE,  TGT_MAILBOX, 12'h064,   4, 32'hFFFF_FFFF));
      pending_req.push_back(make_req(REQ_WRITE, TGT_CTRL,    CR_OFFSET, 4, 32'h00FF_0009));
      pending_req.push_back(make_req(REQ_ACK,   TGT_MAILBOX, OFS_LAST,  7, 32'hFFFF_FFFF));
      wait_idle();

      set_csr(CSR_SERIAL_LO, '1);
      set_csr(CSR_SERIAL_HI, '1);
      set_csr(CSR_SERIAL_LEN, 64'd16);
      run_phase(140);

      set_csr(CSR_SERIAL_LO, {$urandom, $urandom});
      set_csr(CSR_SERIAL_HI, {$urandom, $urandom});
      set_csr(CSR_SERIAL_LEN, 64'd0);
      run_phase(140);

      set_csr(CSR_SERIAL_LO, {$urandom, $urandom});
      set_csr(CSR_SERIAL_LEN, 64'd31);
      run_phase(140);

      set_csr(CSR_UNUSED, {$urandom, $urandom});
      set_csr(CSR_SERIAL_HI, '0);
      set_csr(CSR_SERIAL_LEN, {$urandom, $urandom});
      run_phase(140);

      repeat (4) begin
         set_csr(CSR_SERIAL_LO, {$urandom, $urandom});
         set_csr(CSR_SERIAL_HI, {$urandom, $urandom});
         set_csr(CSR_SERIAL_LEN, 64'($urandom_range(0, 31)));
         run_phase(140);
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_rsp.size()));
      $display("covered %0d transactions under %0d serial settings, %0d service runs",
               checked, csr_settings, service_runs);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
src/smb_pkg.sv
src/smb_if.sv
src/smb_mailbox.sv
src/service_mailbox_controller.sv
dv/tb_service_mailbox_controller.sv
